// ===== design/uwec_pkg.sv =====
`timescale 1ns / 1ps

package uwec_pkg;

  localparam int unsigned DefCountWidth = 32;
  localparam int unsigned OutWidth      = 32;
  localparam int unsigned CpWidth       = 21;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } utf8_in_t;

  typedef struct packed {
    logic [OutWidth-1:0] word_total;
    logic [OutWidth-1:0] emoji_total;
  } utf8_out_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChLf) ||
           (b == ChVt) || (b == ChFf) || (b == ChCr);
  endfunction

  function automatic logic in_range(input logic [CpWidth-1:0] cp,
                                    input logic [CpWidth-1:0] lo,
                                    input logic [CpWidth-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  function automatic logic is_pictograph(input logic [CpWidth-1:0] cp);
    logic excluded;
    logic hit;
    excluded = (cp == 21'h0FE0F) || (cp == 21'h0FE0E) ||
               in_range(cp, 21'h1F3FB, 21'h1F3FF);
    hit = in_range(cp, 21'h1F300, 21'h1FAFF) ||
          in_range(cp, 21'h1F000, 21'h1F02F) ||
          in_range(cp, 21'h1F0A0, 21'h1F0FF) ||
          in_range(cp, 21'h02600, 21'h027BF) ||
          in_range(cp, 21'h1F1E6, 21'h1F1FF) ||
          (cp == 21'h02B50) || (cp == 21'h02B55) ||
          (cp == 21'h02122) || (cp == 21'h02139) ||
          in_range(cp, 21'h02194, 21'h021AA) ||
          in_range(cp, 21'h0231A, 21'h0231B) ||
          in_range(cp, 21'h023E9, 21'h023FA);
    return hit && !excluded;
  endfunction

endpackage

// ===== design/utf8_word_emoji_counter.sv =====
`timescale 1ns / 1ps

// Counts whitespace-delimited words and emoji code points in a UTF-8 text.
// Bytes arrive on the input channel (in_valid_i, in_stall_o, in_data_i), one
// transaction per byte; the final byte of a text carries end_of_text. For
// that byte alone one transaction leaves on the output channel (out_valid_o,
// out_stall_i, out_data_o) with both totals, each saturated at the counter
// width and at 32 bits, after which the counters clear for the next text.
// Throughput is one byte per cycle while in_stall_o is low. A byte is first
// held in an input register, where the decoder and counters update; a final
// byte then loads the result register. While a result waits under
// out_stall_i, ordinary bytes are still taken; only a further final byte
// stalls the input until the output frees. Reset clears both registers'
// valid flags, the counters and the decoder.
module utf8_word_emoji_counter
  import uwec_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  utf8_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output utf8_out_t out_data_o
);

  logic                   s1_valid_q;
  utf8_in_t               s1_data_q;
  logic                   inside_q, inside_d;
  logic [COUNT_WIDTH-1:0] words_q, words_d;
  logic [COUNT_WIDTH-1:0] emoji_q, emoji_d;
  logic [1:0]             cont_q, cont_d;
  logic [CpWidth-1:0]     cp_q, cp_d;
  logic                   out_valid_q;
  utf8_out_t              out_data_q, out_data_d;
  logic                   advance;
  logic                   point_done;
  logic [CpWidth-1:0]     point;
  logic [7:0]             b;
  logic [63:0]            words_ext, emoji_ext;

  assign advance    = s1_valid_q &&
                      !(s1_data_q.end_of_text && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign b          = s1_data_q.text_byte;

  always_comb begin
    inside_d   = inside_q;
    words_d    = words_q;
    emoji_d    = emoji_q;
    cont_d     = cont_q;
    cp_d       = cp_q;
    point_done = 1'b0;
    point      = cp_q;

    if (is_space(b)) begin
      inside_d = 1'b0;
    end else if (!inside_q) begin
      inside_d = 1'b1;
      if (words_q != '1) begin
        words_d = words_q + COUNT_WIDTH'(1);
      end
    end

    if ((cont_q != 2'd0) && ((b & ContMask) == ContCode)) begin
      cp_d   = {cp_q[CpWidth-7:0], b[5:0]};
      cont_d = cont_q - 2'd1;
      if (cont_q == 2'd1) begin
        point_done = 1'b1;
        point      = cp_d;
      end
    end else begin
      cont_d = 2'd0;
      cp_d   = '0;
      if (!b[7]) begin
        point_done = 1'b1;
        point      = CpWidth'(b);
      end else if ((b & Lead2Mask) == Lead2Code) begin
        cp_d   = CpWidth'(b[4:0]);
        cont_d = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        cp_d   = CpWidth'(b[3:0]);
        cont_d = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        cp_d   = CpWidth'(b[2:0]);
        cont_d = 2'd3;
      end
    end

    if (point_done && is_pictograph(point) && (emoji_q != '1)) begin
      emoji_d = emoji_q + COUNT_WIDTH'(1);
    end

    words_ext = 64'(words_d);
    emoji_ext = 64'(emoji_d);
    out_data_d.word_total  = (|words_ext[63:OutWidth]) ? '1 : words_ext[OutWidth-1:0];
    out_data_d.emoji_total = (|emoji_ext[63:OutWidth]) ? '1 : emoji_ext[OutWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      words_q     <= '0;
      emoji_q     <= '0;
      cont_q      <= 2'd0;
      cp_q        <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        if (s1_data_q.end_of_text) begin
          inside_q    <= 1'b0;
          words_q     <= '0;
          emoji_q     <= '0;
          cont_q      <= 2'd0;
          cp_q        <= '0;
          out_valid_q <= 1'b1;
        end else begin
          inside_q <= inside_d;
          words_q  <= words_d;
          emoji_q  <= emoji_d;
          cont_q   <= cont_d;
          cp_q     <= cp_d;
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (advance && s1_data_q.end_of_text) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/uwec_checker.sv =====
`timescale 1ns / 1ps

module uwec_checker
  import uwec_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input utf8_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input utf8_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Output payload changed while stalled.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled although the output is free.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && in_data_i.end_of_text, 2))
    else $error("Result appeared without a final byte two cycles earlier.");

endmodule

bind utf8_word_emoji_counter uwec_checker u_uwec_checker (.*);
